FILE: sv/ild_pkg.sv
// Shared types, constants and the opcode class ROM of the instruction length decoder.
// No dependencies; imported by ild_core and the top level.
package ild_pkg;

	localparam int MAX_LENGTH   = 15;
	localparam int MAX_PREFIXES = 16;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_OPCODE2,
		PH_MODRM,
		PH_SIB,
		PH_OPERANDS
	} phase_t;

	// Prefix set bits
	localparam logic [6:0] PF_NONE = 7'h01;
	localparam logic [6:0] PF_F2   = 7'h02;
	localparam logic [6:0] PF_F3   = 7'h04;
	localparam logic [6:0] PF_66   = 7'h08;
	localparam logic [6:0] PF_67   = 7'h10;
	localparam logic [6:0] PF_LOCK = 7'h20;
	localparam logic [6:0] PF_SEG  = 7'h40;

	// Opcode class bits
	localparam logic [7:0] CL_MODRM = 8'h01;
	localparam logic [7:0] CL_IMM8  = 8'h02;
	localparam logic [7:0] CL_IMM16 = 8'h04;
	localparam logic [7:0] CL_IMMSZ = 8'h10;
	localparam logic [7:0] CL_REL8  = 8'h20;
	localparam logic [7:0] CL_REL32 = 8'h40;

	// Operand form bits
	localparam logic [9:0] FM_MODRM  = 10'h001;
	localparam logic [9:0] FM_SIB    = 10'h002;
	localparam logic [9:0] FM_IMM8   = 10'h004;
	localparam logic [9:0] FM_IMM16  = 10'h008;
	localparam logic [9:0] FM_IMM32  = 10'h010;
	localparam logic [9:0] FM_DISP8  = 10'h020;
	localparam logic [9:0] FM_DISP16 = 10'h040;
	localparam logic [9:0] FM_DISP32 = 10'h080;
	localparam logic [9:0] FM_REL    = 10'h100;
	localparam logic [9:0] FM_2IMM16 = 10'h200;

	// Error kinds
	localparam logic [3:0] ER_OPCODE  = 4'h1;
	localparam logic [3:0] ER_LENGTH  = 4'h2;
	localparam logic [3:0] ER_LOCK    = 4'h4;
	localparam logic [3:0] ER_OPERAND = 4'h8;

	// ROM section offsets
	localparam int OFS_TWO       = 'h4a;
	localparam int OFS_FPU_REG   = 'hf1;
	localparam int OFS_FPU_MODRM = 'hf8;
	localparam int OFS_PREFIX    = 'h130;
	localparam int OFS_LOCK1     = 'h1a1;
	localparam int OFS_LOCK2     = 'h1b9;
	localparam int OFS_MEM1      = 'h1cb;
	localparam int OFS_MEM2      = 'h1da;
	localparam int ROM_DEPTH     = 516;

	localparam int LOCK1_N = (OFS_LOCK2 - OFS_LOCK1) / 2;
	localparam int LOCK2_N = (OFS_MEM1 - OFS_LOCK2) / 2;
	localparam int MEM1_N  = (OFS_MEM2 - OFS_MEM1) / 3;
	localparam int MEM2_N  = (ROM_DEPTH - OFS_MEM2) / 3;

	localparam logic [7:0] CLS_ROM [0:ROM_DEPTH-1] = '{
		8'ha3, 8'ha8, 8'ha3, 8'ha8, 8'ha3, 8'ha8, 8'ha3, 8'ha8, 8'ha3, 8'ha8,
		8'ha3, 8'ha8, 8'ha3, 8'ha8, 8'ha3, 8'ha8, 8'haa, 8'haa, 8'haa,
		8'haa, 8'haa, 8'haa, 8'haa, 8'haa, 8'hac, 8'haa, 8'hb2, 8'haa, 8'h9f,
		8'h9f, 8'h9f, 8'h9f, 8'hb5, 8'ha3, 8'ha3, 8'ha4, 8'haa, 8'haa,
		8'hba, 8'haa, 8'h96, 8'haa, 8'ha8, 8'haa, 8'hc3, 8'hc3, 8'h96, 8'h96,
		8'hb7, 8'hae, 8'hd6, 8'hbd, 8'ha3, 8'hc5, 8'ha3, 8'ha3, 8'h9f,
		8'hc3, 8'h9c, 8'haa, 8'haa, 8'hac, 8'haa, 8'hbf, 8'h03, 8'h7f, 8'h11,
		8'h7f, 8'h01, 8'h7f, 8'h01, 8'h3f, 8'h01, 8'h01, 8'h90, 8'h82,
		8'h7d, 8'h97, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h7f, 8'h59, 8'h59,
		8'h60, 8'h7d, 8'h7f, 8'h7f, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59,
		8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h9a, 8'h88, 8'h7d,
		8'h59, 8'h50, 8'h50, 8'h50, 8'h50, 8'h59, 8'h59, 8'h59, 8'h59,
		8'h61, 8'h94, 8'h61, 8'h9e, 8'h59, 8'h59, 8'h85, 8'h59, 8'h92, 8'ha3,
		8'h60, 8'h60, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59, 8'h59,
		8'h59, 8'h59, 8'h59, 8'h59, 8'h9f, 8'h01, 8'h03, 8'h01, 8'h04, 8'h03,
		8'hd5, 8'h03, 8'hcc, 8'h01, 8'hbc, 8'h03, 8'hf0, 8'h10, 8'h10,
		8'h10, 8'h10, 8'h50, 8'h50, 8'h50, 8'h50, 8'h14, 8'h20, 8'h20, 8'h20,
		8'h20, 8'h01, 8'h01, 8'h01, 8'h01, 8'hc4, 8'h02, 8'h10, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hc0, 8'hc2, 8'h10, 8'h11, 8'h02,
		8'h03, 8'h11, 8'h03, 8'h03, 8'h04, 8'h00, 8'h00, 8'h14, 8'h00,
		8'h02, 8'h00, 8'h00, 8'hc6, 8'hc8, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00,
		8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff,
		8'hca, 8'h01, 8'h01, 8'h01, 8'h00, 8'h06, 8'h00, 8'h04, 8'h00, 8'hc0,
		8'hc2, 8'h01, 8'h01, 8'h03, 8'h01, 8'hff, 8'hff, 8'h01, 8'h00,
		8'h03, 8'hc4, 8'hc4, 8'hc6, 8'h03, 8'h01, 8'h01, 8'h01, 8'hff, 8'h03,
		8'h03, 8'h03, 8'hc8, 8'h40, 8'h00, 8'h0a, 8'h00, 8'h04, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h33, 8'h01, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'hff, 8'hbf, 8'hff, 8'hff, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hbf, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h00, 8'hff,
		8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4b, 8'h52, 8'h4a, 8'h4a, 8'h4a, 8'h4a,
		8'h4f, 8'h4c, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a,
		8'h4a, 8'h55, 8'h45, 8'h40, 8'h4a, 8'h4a, 8'h4a, 8'h45, 8'h59, 8'h4d,
		8'h46, 8'h4a, 8'h5d, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a,
		8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h4a, 8'h61, 8'h63,
		8'h67, 8'h4e, 8'h4a, 8'h4a, 8'h6b, 8'h6d, 8'h4a, 8'h4a, 8'h45,
		8'h6d, 8'h4a, 8'h4a, 8'h44, 8'h45, 8'h4a, 8'h4a, 8'h00, 8'h00, 8'h00,
		8'h02, 8'h0d, 8'h06, 8'h06, 8'h06, 8'h06, 8'h0e, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h06, 8'h06, 8'h06, 8'h00, 8'h06, 8'h06, 8'h02, 8'h06,
		8'h00, 8'h0a, 8'h0a, 8'h07, 8'h07, 8'h06, 8'h02, 8'h05, 8'h05,
		8'h02, 8'h02, 8'h00, 8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00, 8'h00,
		8'h00, 8'h0e, 8'h05, 8'h06, 8'h06, 8'h06, 8'h01, 8'h06, 8'h00,
		8'h00, 8'h08, 8'h00, 8'h10, 8'h00, 8'h18, 8'h00, 8'h20, 8'h00, 8'h28,
		8'h00, 8'h30, 8'h00, 8'h80, 8'h01, 8'h82, 8'h01, 8'h86, 8'h00,
		8'hf6, 8'hcf, 8'hfe, 8'h3f, 8'hab, 8'h00, 8'hb0, 8'h00, 8'hb1, 8'h00,
		8'hb3, 8'h00, 8'hba, 8'hf8, 8'hbb, 8'h00, 8'hc0, 8'h00, 8'hc1,
		8'h00, 8'hc7, 8'hbf, 8'h62, 8'hff, 8'h00, 8'h8d, 8'hff, 8'h00, 8'hc4,
		8'hff, 8'h00, 8'hc5, 8'hff, 8'h00, 8'hff, 8'hff, 8'heb, 8'h01,
		8'hff, 8'h0e, 8'h12, 8'h08, 8'h00, 8'h13, 8'h09, 8'h00, 8'h16, 8'h08,
		8'h00, 8'h17, 8'h09, 8'h00, 8'h2b, 8'h09, 8'h00, 8'hae, 8'hff,
		8'h07, 8'hb2, 8'hff, 8'h00, 8'hb4, 8'hff, 8'h00, 8'hb5, 8'hff, 8'h00,
		8'hc3, 8'h01, 8'h00, 8'hc7, 8'hff, 8'hbf, 8'he7, 8'h08, 8'h00,
		8'hf0, 8'h02, 8'h00
	};

	// One decoded instruction
	typedef struct packed {
		logic [3:0]  length;
		logic [3:0]  error_kinds;
		logic [5:0]  prefix_mask;
		logic [7:0]  opcode_first;
		logic [7:0]  opcode_second;
		logic [7:0]  modrm_value;
		logic [7:0]  sib_value;
		logic [9:0]  operand_forms;
		logic [31:0] immediate_value;
		logic [31:0] displacement_value;
		logic [3:0]  reloc_offset;
		logic        reloc_valid;
	} ild_result_t;

	// ROM read; addresses past the end read zero
	function automatic logic [7:0] rom_rd(logic [9:0] idx);
		logic [7:0] v;
		v = 8'h00;
		if (idx < 10'(ROM_DEPTH)) v = CLS_ROM[idx];
		return v;
	endfunction

	// Map a byte to its prefix bit, zero if not a prefix
	function automatic logic [6:0] prefix_bit(logic [7:0] b);
		logic [6:0] p;
		case (b)
			8'hf3: p = PF_F3;
			8'hf2: p = PF_F2;
			8'hf0: p = PF_LOCK;
			8'h26, 8'h2e, 8'h36, 8'h3e, 8'h64, 8'h65: p = PF_SEG;
			8'h66: p = PF_66;
			8'h67: p = PF_67;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

	// LOCK legality: first matching key in the lock list decides
	function automatic logic lock_ok(logic two, logic [7:0] key, logic [2:0] rg);
		logic hit;
		logic ok;
		hit = 1'b0;
		ok  = 1'b0;
		if (!two) begin
			for (int i = 0; i < LOCK1_N; i++) begin
				if (!hit && CLS_ROM[OFS_LOCK1 + 2*i] == key) begin
					hit = 1'b1;
					ok  = !CLS_ROM[OFS_LOCK1 + 2*i + 1][~rg];
				end
			end
		end else begin
			for (int i = 0; i < LOCK2_N; i++) begin
				if (!hit && CLS_ROM[OFS_LOCK2 + 2*i] == key) begin
					hit = 1'b1;
					ok  = !CLS_ROM[OFS_LOCK2 + 2*i + 1][~rg];
				end
			end
		end
		return ok;
	endfunction

	// Register form of a memory-only opcode: first matching entry decides
	function automatic logic mem_bad(logic two, logic [7:0] op, logic [6:0] pe,
			logic [2:0] rg);
		logic hit;
		logic bad;
		hit = 1'b0;
		bad = 1'b0;
		if (!two) begin
			for (int i = 0; i < MEM1_N; i++) begin
				if (!hit && CLS_ROM[OFS_MEM1 + 3*i] == op) begin
					hit = 1'b1;
					bad = ((CLS_ROM[OFS_MEM1 + 3*i + 1] & {1'b0, pe}) != 8'h00)
						&& !CLS_ROM[OFS_MEM1 + 3*i + 2][~rg];
				end
			end
		end else begin
			for (int i = 0; i < MEM2_N; i++) begin
				if (!hit && CLS_ROM[OFS_MEM2 + 3*i] == op) begin
					hit = 1'b1;
					bad = ((CLS_ROM[OFS_MEM2 + 3*i + 1] & {1'b0, pe}) != 8'h00)
						&& !CLS_ROM[OFS_MEM2 + 3*i + 2][~rg];
				end
			end
		end
		return bad;
	endfunction

endpackage

FILE: sv/ild_core.sv
// Decode state and single-pass byte step of the instruction length decoder.
// Depends on ild_pkg for the class ROM, codes and the result type.
module ild_core
	import ild_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  code_byte,
	output logic        res_valid,
	output ild_result_t res
);

	phase_t      phase_q, n_phase;
	logic [4:0]  bc_q, n_bc;
	logic [6:0]  seen_q, n_seen;
	logic [6:0]  pe_q, n_pe;
	logic        two_q, n_two;
	logic [7:0]  class_q, n_class;
	logic [7:0]  group_q, n_group;
	logic [7:0]  opc_q, n_opc;
	logic [7:0]  opc2_q, n_opc2;
	logic [7:0]  modrm_q, n_modrm;
	logic [7:0]  sib_q, n_sib;
	logic [3:0]  err_q, n_err;
	logic [9:0]  forms_q, n_forms;
	logic [2:0]  dleft_q, n_dleft;
	logic [2:0]  ileft_q, n_ileft;
	logic [2:0]  dsize_q, n_dsize;
	logic [31:0] dacc_q, n_dacc;
	logic [31:0] iacc_q, n_iacc;
	logic        pdest_q [4];
	logic        n_pdest [4];
	logic [2:0]  psize_q [4];
	logic [2:0]  n_psize [4];
	logic [2:0]  pcnt_q, n_pcnt;
	logic [2:0]  ppos_q, n_ppos;

	logic        do_after, do_modrm, do_ops, do_fin, do_clr;
	logic [6:0]  pb;
	logic [9:0]  base, gi;
	logic [7:0]  t, t2, cf, op, fv;
	logic [1:0]  md;
	logic [2:0]  rg, rmf, ft, fsel, cnt;
	logic [1:0]  emod;
	logic        bad, done, wide;
	logic [1:0]  lane;
	logic [4:0]  len5;
	logic [3:0]  fe, off;
	logic        rv;

	// Advance the decode by one code byte
	always_comb begin
		n_phase = phase_q; n_bc = bc_q; n_seen = seen_q; n_pe = pe_q; n_two = two_q;
		n_class = class_q; n_group = group_q; n_opc = opc_q; n_opc2 = opc2_q;
		n_modrm = modrm_q; n_sib = sib_q; n_err = err_q; n_forms = forms_q;
		n_dleft = dleft_q; n_ileft = ileft_q; n_dsize = dsize_q;
		n_dacc = dacc_q; n_iacc = iacc_q; n_pcnt = pcnt_q; n_ppos = ppos_q;
		for (int i = 0; i < 4; i++) begin
			n_pdest[i] = pdest_q[i];
			n_psize[i] = psize_q[i];
		end
		do_after = 1'b0; do_modrm = 1'b0; do_ops = 1'b0; do_fin = 1'b0; do_clr = 1'b0;
		pb = '0; base = '0; gi = '0; t = '0; t2 = '0; cf = '0; op = '0; fv = '0;
		md = '0; rg = '0; rmf = '0; ft = '0; fsel = '0; cnt = '0; emod = '0;
		bad = 1'b0; done = 1'b0; wide = 1'b0; lane = '0; len5 = '0; fe = '0;
		off = '0; rv = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (bc_q != 5'd31) n_bc = bc_q + 5'd1;

		case (phase_q)
			PH_PREFIX: begin
				pb = prefix_bit(code_byte);
				n_seen = seen_q | pb;
				if (pb == 7'h00 || n_bc >= 5'(MAX_PREFIXES)) begin
					n_opc = code_byte;
					n_pe = (n_seen != 7'h00) ? n_seen : PF_NONE;
					if (code_byte == 8'h0f) begin
						n_two = 1'b1;
						n_phase = PH_OPCODE2;
					end else begin
						// moffs forms follow the address size
						if (code_byte >= 8'ha0 && code_byte <= 8'ha3) begin
							if ((n_pe & PF_67) != 7'h00) n_pe = n_pe | PF_66;
							else n_pe = n_pe & ~PF_66;
						end
						do_after = 1'b1;
					end
				end
			end
			PH_OPCODE2: begin
				n_opc2 = code_byte;
				do_after = 1'b1;
			end
			PH_MODRM: do_modrm = 1'b1;
			PH_SIB: begin
				n_sib = code_byte;
				if (code_byte[2:0] == 3'd5 && !modrm_q[6]) n_dsize = 3'd4;
				do_ops = 1'b1;
			end
			PH_OPERANDS: begin
				if (dleft_q != 3'd0) begin
					lane = 2'(dsize_q - dleft_q);
					n_dacc[{lane, 3'b000} +: 8] = code_byte;
					n_dleft = dleft_q - 3'd1;
				end else if (ppos_q < pcnt_q && ppos_q < 3'd4 && ileft_q != 3'd0) begin
					lane = 2'(psize_q[ppos_q[1:0]] - ileft_q);
					if (pdest_q[ppos_q[1:0]]) n_dacc[{lane, 3'b000} +: 8] = code_byte;
					else n_iacc[{lane, 3'b000} +: 8] = code_byte;
					n_ileft = ileft_q - 3'd1;
					if (n_ileft == 3'd0) begin
						n_ppos = ppos_q + 3'd1;
						if (n_ppos < pcnt_q && n_ppos < 3'd4) n_ileft = psize_q[n_ppos[1:0]];
					end
				end
				if (n_dleft == 3'd0 && (n_ppos >= n_pcnt || n_ileft == 3'd0)) do_fin = 1'b1;
			end
			default: do_clr = 1'b1;
		endcase

		// Classify the opcode through the ROM
		if (do_after) begin
			base = n_two ? 10'(OFS_TWO) : 10'd0;
			t = rom_rd(base + 10'(code_byte[7:2]));
			cf = rom_rd(base + 10'(t) + 10'(code_byte[1:0]));
			n_group = 8'h00;
			if (cf == 8'hff) begin
				n_err = n_err | ER_OPCODE;
				cf = ((code_byte & 8'hfd) == 8'h24) ? 8'h01 : 8'h00;
			end
			if (cf[7]) begin
				gi = base + 10'(cf[6:0]);
				cf = rom_rd(gi);
				n_group = rom_rd(gi + 10'd1);
			end
			if (n_two) begin
				t2 = rom_rd(10'(OFS_PREFIX) + 10'(code_byte[7:2]));
				if ((rom_rd(10'(OFS_PREFIX) + 10'(t2) + 10'(code_byte[1:0]))
						& {1'b0, n_pe}) != 8'h00)
					n_err = n_err | ER_OPCODE;
			end
			n_class = cf;
			if ((cf & CL_MODRM) != 8'h00) begin
				n_forms = n_forms | FM_MODRM;
				n_phase = PH_MODRM;
			end else begin
				if ((n_pe & PF_LOCK) != 7'h00) n_err = n_err | ER_LOCK;
				n_dsize = 3'd0;
				do_ops = 1'b1;
			end
		end

		// Check the ModRM byte and size the displacement
		if (do_modrm) begin
			md = code_byte[7:6];
			rg = code_byte[5:3];
			rmf = code_byte[2:0];
			emod = md;
			op = two_q ? opc2_q : opc_q;
			n_modrm = code_byte;
			if (group_q != 8'h00 && group_q[~rg]) n_err = n_err | ER_OPCODE;
			if (!two_q && op >= 8'hd9 && op <= 8'hdf) begin
				ft = 3'(op - 8'hd9);
				if (md == 2'd3) fv = rom_rd(10'(OFS_FPU_MODRM) + 10'({ft, rg}));
				else fv = rom_rd(10'(OFS_FPU_REG) + 10'(ft));
				fsel = (md == 2'd3) ? rmf : rg;
				if (fv[~fsel]) n_err = n_err | ER_OPCODE;
			end
			if ((pe_q & PF_LOCK) != 7'h00) begin
				if (md == 2'd3) n_err = n_err | ER_LOCK;
				else if (!lock_ok(two_q, two_q ? op : (op & 8'hfe), rg))
					n_err = n_err | ER_LOCK;
			end
			// Control, debug and segment register moves
			if (two_q) begin
				if (op == 8'h20 || op == 8'h22) begin
					emod = 2'd3; bad = rg > 3'd4 || rg == 3'd1; done = 1'b1;
				end else if (op == 8'h21 || op == 8'h23) begin
					emod = 2'd3; bad = rg == 3'd4 || rg == 3'd5; done = 1'b1;
				end
			end else begin
				if (op == 8'h8c) begin
					bad = rg > 3'd5; done = 1'b1;
				end else if (op == 8'h8e) begin
					bad = rg == 3'd1 || rg > 3'd5; done = 1'b1;
				end
			end
			if (!done) begin
				if (md == 2'd3) bad = mem_bad(two_q, op, pe_q, rg);
				else if (two_q) begin
					if (op == 8'h50 || op == 8'hd7 || op == 8'hf7)
						bad = (pe_q & (PF_NONE | PF_66)) != 7'h00;
					else if (op == 8'hd6)
						bad = (pe_q & (PF_F2 | PF_F3)) != 7'h00;
					else if (op == 8'hc5)
						bad = 1'b1;
				end
			end
			if (bad) n_err = n_err | ER_OPERAND;
			// Group 3 test forms carry an immediate
			if (!two_q && rg <= 3'd1) begin
				if (op == 8'hf6) n_class = n_class | CL_IMM8;
				else if (op == 8'hf7) n_class = n_class | CL_IMMSZ;
			end
			n_dsize = 3'd0;
			if (emod == 2'd0) begin
				if ((pe_q & PF_67) != 7'h00) begin
					if (rmf == 3'd6) n_dsize = 3'd2;
				end else if (rmf == 3'd5) n_dsize = 3'd4;
			end else if (emod == 2'd1) n_dsize = 3'd1;
			else if (emod == 2'd2) n_dsize = ((pe_q & PF_67) != 7'h00) ? 3'd2 : 3'd4;
			if (emod != 2'd3 && rmf == 3'd4 && (pe_q & PF_67) == 7'h00) begin
				n_forms = n_forms | FM_SIB;
				n_phase = PH_SIB;
			end else begin
				do_ops = 1'b1;
			end
		end

		// Plan displacement and immediate pieces
		if (do_ops) begin
			if (n_dsize == 3'd1) n_forms = n_forms | FM_DISP8;
			else if (n_dsize == 3'd2) n_forms = n_forms | FM_DISP16;
			else if (n_dsize == 3'd4) n_forms = n_forms | FM_DISP32;
			wide = (n_pe & PF_66) != 7'h00;
			cnt = 3'd0;
			done = 1'b0;
			if ((n_class & CL_IMMSZ) != 8'h00) begin
				if ((n_class & CL_REL32) != 8'h00) begin
					n_forms = n_forms | FM_REL | (wide ? FM_IMM16 : FM_IMM32);
					done = 1'b1;
				end else begin
					n_forms = n_forms | (wide ? FM_IMM16 : FM_IMM32);
				end
				n_pdest[cnt[1:0]] = 1'b0;
				n_psize[cnt[1:0]] = wide ? 3'd2 : 3'd4;
				cnt = cnt + 3'd1;
			end
			if (!done) begin
				if ((n_class & CL_IMM16) != 8'h00) begin
					if ((n_forms & FM_IMM32) != 10'h000) begin
						n_forms = n_forms | FM_IMM16;
						n_pdest[cnt[1:0]] = 1'b1;
					end else if ((n_forms & FM_IMM16) != 10'h000) begin
						n_forms = n_forms | FM_2IMM16;
						n_pdest[cnt[1:0]] = 1'b1;
					end else begin
						n_forms = n_forms | FM_IMM16;
						n_pdest[cnt[1:0]] = 1'b0;
					end
					n_psize[cnt[1:0]] = 3'd2;
					cnt = cnt + 3'd1;
				end
				if ((n_class & CL_IMM8) != 8'h00) begin
					n_forms = n_forms | FM_IMM8;
					n_pdest[cnt[1:0]] = 1'b0;
					n_psize[cnt[1:0]] = 3'd1;
					cnt = cnt + 3'd1;
				end
				if ((n_class & CL_REL32) != 8'h00) begin
					n_forms = n_forms | FM_IMM32 | FM_REL;
					n_pdest[cnt[1:0]] = 1'b0;
					n_psize[cnt[1:0]] = 3'd4;
					cnt = cnt + 3'd1;
				end else if ((n_class & CL_REL8) != 8'h00) begin
					n_forms = n_forms | FM_IMM8 | FM_REL;
					n_pdest[cnt[1:0]] = 1'b0;
					n_psize[cnt[1:0]] = 3'd1;
					cnt = cnt + 3'd1;
				end
			end
			n_pcnt = cnt;
			n_dleft = n_dsize;
			n_ppos = 3'd0;
			n_ileft = (cnt != 3'd0) ? n_psize[0] : 3'd0;
			if (n_dleft == 3'd0 && n_ileft == 3'd0) do_fin = 1'b1;
			else n_phase = PH_OPERANDS;
		end

		// Emit the instruction and start over
		if (do_fin) begin
			len5 = n_bc;
			fe = n_err;
			if (len5 > 5'(MAX_LENGTH)) begin
				fe = fe | ER_LENGTH;
				len5 = 5'(MAX_LENGTH);
			end
			if ((n_forms & FM_REL) != 10'h000 && fe == 4'h0) begin
				if ((n_forms & FM_IMM32) != 10'h000) off = len5[3:0] - 4'd4;
				else if ((n_forms & FM_IMM16) != 10'h000) off = len5[3:0] - 4'd2;
				else off = len5[3:0] - 4'd1;
				rv = 1'b1;
			end
			res.length = len5[3:0];
			res.error_kinds = fe;
			res.prefix_mask = n_seen[6:1];
			res.opcode_first = n_opc;
			res.opcode_second = n_two ? n_opc2 : 8'h00;
			res.modrm_value = n_modrm;
			res.sib_value = n_sib;
			res.operand_forms = n_forms;
			res.immediate_value = n_iacc;
			res.displacement_value = n_dacc;
			res.reloc_offset = off;
			res.reloc_valid = rv;
			res_valid = 1'b1;
			do_clr = 1'b1;
		end

		if (do_clr) begin
			n_phase = PH_PREFIX; n_bc = '0; n_seen = '0; n_pe = '0; n_two = 1'b0;
			n_class = '0; n_group = '0; n_opc = '0; n_opc2 = '0; n_modrm = '0;
			n_sib = '0; n_err = '0; n_forms = '0; n_dleft = '0; n_ileft = '0;
			n_dsize = '0; n_dacc = '0; n_iacc = '0; n_pcnt = '0; n_ppos = '0;
			for (int i = 0; i < 4; i++) begin
				n_pdest[i] = 1'b0;
				n_psize[i] = '0;
			end
		end
	end

	// Hold decode state; update on each stepped byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; bc_q <= '0; seen_q <= '0; pe_q <= '0; two_q <= 1'b0;
			class_q <= '0; group_q <= '0; opc_q <= '0; opc2_q <= '0; modrm_q <= '0;
			sib_q <= '0; err_q <= '0; forms_q <= '0; dleft_q <= '0; ileft_q <= '0;
			dsize_q <= '0; dacc_q <= '0; iacc_q <= '0; pcnt_q <= '0; ppos_q <= '0;
			for (int i = 0; i < 4; i++) begin
				pdest_q[i] <= 1'b0;
				psize_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= n_phase; bc_q <= n_bc; seen_q <= n_seen; pe_q <= n_pe;
			two_q <= n_two; class_q <= n_class; group_q <= n_group; opc_q <= n_opc;
			opc2_q <= n_opc2; modrm_q <= n_modrm; sib_q <= n_sib; err_q <= n_err;
			forms_q <= n_forms; dleft_q <= n_dleft; ileft_q <= n_ileft;
			dsize_q <= n_dsize; dacc_q <= n_dacc; iacc_q <= n_iacc;
			pcnt_q <= n_pcnt; ppos_q <= n_ppos;
			for (int i = 0; i < 4; i++) begin
				pdest_q[i] <= n_pdest[i];
				psize_q[i] <= n_psize[i];
			end
		end
	end

endmodule

FILE: sv/x86_instruction_length_decoder.sv
// Top level of the 32-bit x86 instruction length decoder: input stage, decode core,
// result register. Depends on ild_pkg and ild_core.
//
// Feed the code stream one byte per item on the slave side; one result item leaves on
// the master side for each instruction, on the cycle after its last byte is stepped.
// Bytes are taken one per clock unless the input side stalls: each byte sits in the
// input register while the decode core classifies it (class ROM, lock and
// register-form tables) and updates its state, and a finished instruction goes to the
// result register. The input side stalls only while a result waits in the result
// register and the core must emit the next one.
module x86_instruction_length_decoder
	import ild_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] code_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] length, [7:4] error_kinds, [13:8] prefix_mask, [21:14] opcode_first,
	// [29:22] opcode_second, [37:30] modrm_value, [45:38] sib_value,
	// [55:46] operand_forms, [87:56] immediate_value, [119:88] displacement_value,
	// [123:120] reloc_offset, [124] reloc_valid, [127:125] zero
	output logic [127:0] m_tdata
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	ild_result_t res_q;
	logic        step;
	logic        core_valid;
	ild_result_t core_res;

	// Step the core when a byte is held and its result, if any, has room
	assign step     = valid_s1 && (!core_valid || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	ild_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.code_byte (byte_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && core_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q.reloc_valid, res_q.reloc_offset,
		res_q.displacement_value, res_q.immediate_value, res_q.operand_forms,
		res_q.sib_value, res_q.modrm_value, res_q.opcode_second, res_q.opcode_first,
		res_q.prefix_mask, res_q.error_kinds, res_q.length};

endmodule

FILE: tb/sv/ild_result_checker.sv
// Checker for the x86 instruction length decoder: watches the byte and result streams,
// predicts each decoded instruction with its own decoder model and compares field by field.
// Depends on ild_pkg for the class ROM, prefix, class, form and error constants.
module ild_result_checker
	import ild_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           fail_count,
	output int           pending_count
);

	ild_result_t decoded_q[$];

	// decoder state
	phase_t      ph;
	int          nbytes;
	logic [6:0]  pseen, peff;
	logic        twob;
	logic [7:0]  cls, gmask, op1, op2, mrm, sibb;
	logic [3:0]  errs;
	logic [9:0]  forms;
	int          dleft, ileft, dsize;
	logic [31:0] dacc, iacc;
	int          pdest[4], psize[4], pcnt, ppos;

	function automatic logic [7:0] rb(int i);
		return (i >= 0 && i < ROM_DEPTH) ? CLS_ROM[i] : 8'h00;
	endfunction

	function automatic logic bit_msb(logic [7:0] v, int pos);
		return v[7 - (pos & 7)];
	endfunction

	// split the result bus into its fields, lowest field first
	function automatic ild_result_t unpack_result(logic [127:0] d);
		ild_result_t r;
		r.length             = d[3:0];
		r.error_kinds        = d[7:4];
		r.prefix_mask        = d[13:8];
		r.opcode_first       = d[21:14];
		r.opcode_second      = d[29:22];
		r.modrm_value        = d[37:30];
		r.sib_value          = d[45:38];
		r.operand_forms      = d[55:46];
		r.immediate_value    = d[87:56];
		r.displacement_value = d[119:88];
		r.reloc_offset       = d[123:120];
		r.reloc_valid        = d[124];
		return r;
	endfunction

	function automatic logic [6:0] pref_of(logic [7:0] b);
		case (b)
			8'hf3: return PF_F3;
			8'hf2: return PF_F2;
			8'hf0: return PF_LOCK;
			8'h26, 8'h2e, 8'h36, 8'h3e, 8'h64, 8'h65: return PF_SEG;
			8'h66: return PF_66;
			8'h67: return PF_67;
			default: return 7'h00;
		endcase
	endfunction

	task automatic clear_decode();
		ph = PH_PREFIX; nbytes = 0; pseen = 0; peff = 0; twob = 0;
		cls = 0; gmask = 0; op1 = 0; op2 = 0; mrm = 0; sibb = 0; errs = 0; forms = 0;
		dleft = 0; ileft = 0; dsize = 0; dacc = 0; iacc = 0; pcnt = 0; ppos = 0;
		for (int i = 0; i < 4; i++) begin
			pdest[i] = 0; psize[i] = 0;
		end
	endtask

	task automatic add_piece(int d, int s);
		if (pcnt < 4) begin
			pdest[pcnt] = d; psize[pcnt] = s; pcnt++;
		end
	endtask

	task automatic plan_imm();
		logic wide;
		wide = (peff & PF_66) != 0;
		if (cls & CL_IMMSZ) begin
			if (cls & CL_REL32) begin
				if (wide) begin forms |= FM_IMM16 | FM_REL; add_piece(0, 2); end
				else begin forms |= FM_IMM32 | FM_REL; add_piece(0, 4); end
				return;
			end
			if (wide) begin forms |= FM_IMM16; add_piece(0, 2); end
			else begin forms |= FM_IMM32; add_piece(0, 4); end
		end
		if (cls & CL_IMM16) begin
			if (forms & FM_IMM32) begin forms |= FM_IMM16; add_piece(1, 2); end
			else if (forms & FM_IMM16) begin forms |= FM_2IMM16; add_piece(1, 2); end
			else begin forms |= FM_IMM16; add_piece(0, 2); end
		end
		if (cls & CL_IMM8) begin forms |= FM_IMM8; add_piece(0, 1); end
		if (cls & CL_REL32) begin forms |= FM_IMM32 | FM_REL; add_piece(0, 4); end
		else if (cls & CL_REL8) begin forms |= FM_IMM8 | FM_REL; add_piece(0, 1); end
	endtask

	task automatic emit_insn();
		ild_result_t r;
		int len;
		logic [3:0] e;
		len = nbytes; e = errs;
		if (len > MAX_LENGTH) begin e |= ER_LENGTH; len = MAX_LENGTH; end
		r = '0;
		if ((forms & FM_REL) && e == 0) begin
			if (forms & FM_IMM32) r.reloc_offset = 4'(len - 4);
			else if (forms & FM_IMM16) r.reloc_offset = 4'(len - 2);
			else r.reloc_offset = 4'(len - 1);
			r.reloc_valid = 1'b1;
		end
		r.length = 4'(len);
		r.error_kinds = e;
		r.prefix_mask = pseen[6:1];
		r.opcode_first = op1;
		r.opcode_second = twob ? op2 : 8'h00;
		r.modrm_value = mrm;
		r.sib_value = sibb;
		r.operand_forms = forms;
		r.immediate_value = iacc;
		r.displacement_value = dacc;
		decoded_q.push_back(r);
		clear_decode();
	endtask

	task automatic enter_operands();
		if (dsize == 1) forms |= FM_DISP8;
		else if (dsize == 2) forms |= FM_DISP16;
		else if (dsize == 4) forms |= FM_DISP32;
		plan_imm();
		dleft = dsize; ppos = 0;
		ileft = pcnt ? psize[0] : 0;
		if (dleft == 0 && ileft == 0) emit_insn();
		else ph = PH_OPERANDS;
	endtask

	task automatic classify(logic [7:0] c);
		int base, g;
		logic [7:0] cf;
		base = twob ? OFS_TWO : 0;
		cf = rb(base + rb(base + c[7:2]) + c[1:0]);
		gmask = 0;
		if (cf == 8'hff) begin
			errs |= ER_OPCODE;
			cf = ((c & 8'hfd) == 8'h24) ? 8'h01 : 8'h00;
		end
		if (cf[7]) begin
			g = base + cf[6:0];
			cf = rb(g); gmask = rb(g + 1);
		end
		if (twob && ((rb(OFS_PREFIX + rb(OFS_PREFIX + c[7:2]) + c[1:0]) & {1'b0, peff}) != 0))
			errs |= ER_OPCODE;
		cls = cf;
		if (cf & CL_MODRM) begin
			forms |= FM_MODRM; ph = PH_MODRM;
		end else begin
			if (peff & PF_LOCK) errs |= ER_LOCK;
			dsize = 0;
			enter_operands();
		end
	endtask

	task automatic take_modrm(logic [7:0] m);
		int md, rg, rm, emd, t, lo, hi;
		logic [7:0] op, v, key;
		logic bad, done, ok;
		md = m[7:6]; rg = m[5:3]; rm = m[2:0]; emd = md;
		op = twob ? op2 : op1;
		bad = 0; done = 0;
		mrm = m;
		if (gmask != 0 && bit_msb(gmask, rg)) errs |= ER_OPCODE;
		if (!twob && op >= 8'hd9 && op <= 8'hdf) begin
			t = op - 8'hd9;
			v = (md == 3) ? rb(OFS_FPU_MODRM + t * 8 + rg) : rb(OFS_FPU_REG + t);
			if (bit_msb(v, md == 3 ? rm : rg)) errs |= ER_OPCODE;
		end
		if (peff & PF_LOCK) begin
			if (md == 3) errs |= ER_LOCK;
			else begin
				lo = twob ? OFS_LOCK2 : OFS_LOCK1;
				hi = twob ? OFS_MEM1 : OFS_LOCK2;
				key = twob ? op : (op & 8'hfe);
				ok = 0;
				for (int i = lo; i + 1 < hi; i += 2)
					if (rb(i) == key) begin
						ok = !bit_msb(rb(i + 1), rg);
						break;
					end
				if (!ok) errs |= ER_LOCK;
			end
		end
		if (twob) begin
			if (op == 8'h20 || op == 8'h22) begin
				emd = 3; bad = rg > 4 || rg == 1; done = 1;
			end else if (op == 8'h21 || op == 8'h23) begin
				emd = 3; bad = rg == 4 || rg == 5; done = 1;
			end
		end else begin
			if (op == 8'h8c) begin bad = rg > 5; done = 1; end
			else if (op == 8'h8e) begin bad = rg == 1 || rg > 5; done = 1; end
		end
		if (!done) begin
			if (md == 3) begin
				lo = twob ? OFS_MEM2 : OFS_MEM1;
				hi = twob ? ROM_DEPTH : OFS_MEM2;
				for (int i = lo; i + 2 < hi; i += 3)
					if (rb(i) == op) begin
						bad = ((rb(i + 1) & {1'b0, peff}) != 0) && !bit_msb(rb(i + 2), rg);
						break;
					end
			end else if (twob) begin
				if (op == 8'h50 || op == 8'hd7 || op == 8'hf7)
					bad = (peff & (PF_NONE | PF_66)) != 0;
				else if (op == 8'hd6) bad = (peff & (PF_F2 | PF_F3)) != 0;
				else if (op == 8'hc5) bad = 1;
			end
		end
		if (bad) errs |= ER_OPERAND;
		// group 3 test forms carry an immediate only as one-byte opcodes
		if (!twob && rg <= 1) begin
			if (op == 8'hf6) cls |= CL_IMM8;
			else if (op == 8'hf7) cls |= CL_IMMSZ;
		end
		dsize = 0;
		if (emd == 0) begin
			if (peff & PF_67) begin
				if (rm == 6) dsize = 2;
			end else if (rm == 5) dsize = 4;
		end else if (emd == 1) dsize = 1;
		else if (emd == 2) dsize = (peff & PF_67) ? 2 : 4;
		if (emd != 3 && rm == 4 && !(peff & PF_67)) begin
			forms |= FM_SIB; ph = PH_SIB;
		end else enter_operands();
	endtask

	task automatic decode_byte(logic [7:0] b);
		logic [6:0] pb;
		int sh;
		if (nbytes < 31) nbytes++;
		case (ph)
			PH_PREFIX: begin
				pb = pref_of(b);
				pseen |= pb;
				if (pb != 0 && nbytes < MAX_PREFIXES) return;
				op1 = b;
				peff = pseen != 0 ? pseen : PF_NONE;
				if (b == 8'h0f) begin
					twob = 1; ph = PH_OPCODE2; return;
				end
				// moffs forms: address size picks the offset width
				if (b >= 8'ha0 && b <= 8'ha3) begin
					if (peff & PF_67) peff |= PF_66;
					else peff &= ~PF_66;
				end
				classify(b);
			end
			PH_OPCODE2: begin
				op2 = b; classify(b);
			end
			PH_MODRM: take_modrm(b);
			PH_SIB: begin
				sibb = b;
				if (b[2:0] == 3'd5 && !mrm[6]) dsize = 4;
				enter_operands();
			end
			PH_OPERANDS: begin
				if (dleft != 0) begin
					sh = 8 * ((dsize - dleft) & 3);
					dacc = (dacc & ~(32'hff << sh)) | (32'(b) << sh);
					dleft--;
				end else if (ppos < pcnt && ileft != 0) begin
					sh = 8 * ((psize[ppos] - ileft) & 3);
					if (pdest[ppos] != 0) dacc = (dacc & ~(32'hff << sh)) | (32'(b) << sh);
					else iacc = (iacc & ~(32'hff << sh)) | (32'(b) << sh);
					ileft--;
					if (ileft == 0) begin
						ppos++;
						if (ppos < pcnt) ileft = psize[ppos];
					end
				end
				if (dleft == 0 && (ppos >= pcnt || ileft == 0)) emit_insn();
			end
			default: clear_decode();
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	task automatic compare_insn(ild_result_t got);
		ild_result_t w;
		if (decoded_q.size() == 0) begin
			report_mismatch("unexpected result, length", got.length, 0);
			return;
		end
		w = decoded_q.pop_front();
		if (got.length != w.length) report_mismatch("length", got.length, w.length);
		if (got.error_kinds != w.error_kinds)
			report_mismatch("error_kinds", got.error_kinds, w.error_kinds);
		if (got.prefix_mask != w.prefix_mask)
			report_mismatch("prefix_mask", got.prefix_mask, w.prefix_mask);
		if (got.opcode_first != w.opcode_first)
			report_mismatch("opcode_first", got.opcode_first, w.opcode_first);
		if (got.opcode_second != w.opcode_second)
			report_mismatch("opcode_second", got.opcode_second, w.opcode_second);
		if (got.modrm_value != w.modrm_value)
			report_mismatch("modrm_value", got.modrm_value, w.modrm_value);
		if (got.sib_value != w.sib_value) report_mismatch("sib_value", got.sib_value, w.sib_value);
		if (got.operand_forms != w.operand_forms)
			report_mismatch("operand_forms", got.operand_forms, w.operand_forms);
		if (got.immediate_value != w.immediate_value)
			report_mismatch("immediate_value", got.immediate_value, w.immediate_value);
		if (got.displacement_value != w.displacement_value)
			report_mismatch("displacement_value", got.displacement_value, w.displacement_value);
		if (got.reloc_offset != w.reloc_offset)
			report_mismatch("reloc_offset", got.reloc_offset, w.reloc_offset);
		if (got.reloc_valid != w.reloc_valid)
			report_mismatch("reloc_valid", got.reloc_valid, w.reloc_valid);
	endtask

	initial begin
		fail_count = 0;
		clear_decode();
	end

	assign pending_count = decoded_q.size();

	// predict on accepted bytes, compare on accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) compare_insn(unpack_result(m_tdata));
			if (s_tvalid && s_tready) decode_byte(s_tdata);
		end
	end

endmodule

FILE: tb/sv/tb_x86_instruction_length_decoder.sv
// Testbench top for the x86 instruction length decoder: clock, reset, byte stimulus
// with random gaps, random result stalls and the verdict. Depends on ild_pkg,
// the decoder and ild_result_checker.
module tb_x86_instruction_length_decoder;
	import ild_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	int           fail_count;
	int           pending_count;
	int           idle_cycles;
	logic         stream_done;
	logic         quiet_rx;

	x86_instruction_length_decoder uut (.*);

	ild_result_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	logic [7:0] code_q[$];

	function automatic logic [7:0] rand_prefix();
		logic [7:0] p[11] = '{8'hf2, 8'hf3, 8'hf0, 8'h66, 8'h67,
			8'h26, 8'h2e, 8'h36, 8'h3e, 8'h64, 8'h65};
		return p[$urandom_range(0, 10)];
	endfunction

	// queue one plausible instruction: prefixes, opcode, then random operand bytes
	task automatic add_random_insn();
		int np;
		np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
		for (int i = 0; i < np; i++) code_q.push_back(rand_prefix());
		if ($urandom_range(0, 3) == 0) code_q.push_back(8'h0f);
		code_q.push_back(8'($urandom));
		for (int i = 0; i < 12; i++) code_q.push_back(8'($urandom));
	endtask

	task automatic add_directed();
		logic [7:0] d[] = '{
			8'h90, 8'h00, 8'hc0, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
			8'he8, 8'h11, 8'h22, 8'h33, 8'h44, 8'heb, 8'h80, 8'h66, 8'he9, 8'h01, 8'h02,
			8'h0f, 8'h00, 8'h00, 8'h0f, 8'h84, 8'h01, 8'h02, 8'h03, 8'h04,
			8'hf6, 8'h00, 8'h55, 8'h0f, 8'hf6, 8'h00, 8'hf0, 8'h01, 8'hc0,
			8'hf0, 8'h01, 8'h00, 8'h0f, 8'h20, 8'hc8, 8'h8e, 8'hc8,
			8'h8b, 8'h84, 8'h24, 8'h78, 8'h56, 8'h34, 8'h12, 8'h67, 8'ha1, 8'h34, 8'h12,
			8'hc8, 8'h10, 8'h20, 8'h30, 8'hd9, 8'hd8, 8'h62, 8'hc0};
		foreach (d[i]) code_q.push_back(d[i]);
		// run of sixteen prefixes, then an overlong instruction
		for (int i = 0; i < 16; i++) code_q.push_back(8'h66);
		for (int i = 0; i < 14; i++) code_q.push_back(8'h2e);
		code_q.push_back(8'h81);
		code_q.push_back(8'h80);
		for (int i = 0; i < 8; i++) code_q.push_back(8'hff);
	endtask

	// byte source: random gap before each item
	initial begin
		int gap;
		logic [7:0] b;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		stream_done = 0;
		add_directed();
		while (code_q.size() < 1800) add_random_insn();
		// padding of nops flushes whatever instruction the stream ends inside
		for (int i = 0; i < 16; i++) code_q.push_back(8'h90);
		repeat (11) @(posedge clk);
		arst_n <= 1;
		while (code_q.size() != 0) begin
			b = code_q.pop_front();
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= b;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		s_tvalid <= 0;
		stream_done <= 1;
	end

	// result sink: random stall per item, with stall-free stretches
	initial begin
		int stall;
		m_tready = 0;
		quiet_rx = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0) quiet_rx = ~quiet_rx;
			stall = quiet_rx ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// watchdog and verdict
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (!(stream_done && pending_count == 0) && idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL x86_instruction_length_decoder");
		end else begin
			repeat (20) @(posedge clk);
			if (fail_count == 0 && pending_count == 0) begin
				$display("PASS x86_instruction_length_decoder");
			end else begin
				$display("FAIL x86_instruction_length_decoder");
			end
		end
		$finish;
	end

endmodule
